// ===== rtl/core/bounding_box_affine_transform_defines.svh =====
// ---------------------------------------------------------------------------
// bounding box affine transform assertion macros
// concurrent checks on the block's own logic, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef BOUNDING_BOX_AFFINE_TRANSFORM_DEFINES_SVH
`define BOUNDING_BOX_AFFINE_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define BBAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbat assertion failed");

// next-cycle implication, disabled during reset
`define BBAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbat assertion failed");

`else

`define BBAT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BBAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/bbat_pkg.sv =====
// ---------------------------------------------------------------------------
// bbat_pkg
// widths, types, register indexes and helpers of the box affine transform
// ---------------------------------------------------------------------------
package bbat_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH  = 16;
    localparam int COEF_FRAC   = COEF_WIDTH - 4;
    localparam int NUM_AXES    = 3;

    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int TERM_WIDTH  = PROD_WIDTH - COEF_FRAC;
    // three terms plus the shift, two bits of growth
    localparam int SUM_WIDTH   = TERM_WIDTH + 2;

    localparam int ROW_WIDTH   = NUM_AXES * COEF_WIDTH;
    localparam int CFG_WIDTH   = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;

    localparam int BOX_WIDTH   = 2 * NUM_AXES * COORD_WIDTH;
    localparam int TDATA_WIDTH = ((BOX_WIDTH + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [TERM_WIDTH-1:0]  term_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [ROW_WIDTH-1:0]          row_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ROW_FROM_X = 3'd0,
        REG_ROW_FROM_Y = 3'd1,
        REG_ROW_FROM_Z = 3'd2,
        REG_SHIFT_X    = 3'd3,
        REG_SHIFT_Y    = 3'd4,
        REG_SHIFT_Z    = 3'd5
    } cfg_idx_t;

    // row[k] holds coefficients applied to input axis k
    typedef struct packed {
        row_t   [NUM_AXES-1:0] row;
        coord_t [NUM_AXES-1:0] shift;
    } cfg_t;

    // per-stage load strobes
    typedef struct packed {
        logic load_prod;
        logic load_ext;
        logic load_sum;
        logic load_out;
    } pipe_ctl_t;

    function automatic coef_t coef_of(row_t row, int out_axis);
        return coef_t'(row[out_axis*COEF_WIDTH +: COEF_WIDTH]);
    endfunction

    // identity row for input axis k
    function automatic row_t ident_row(int in_axis);
        row_t r;
        r = '0;
        r[in_axis*COEF_WIDTH + COEF_FRAC] = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/bbat_cfg.sv =====
// ---------------------------------------------------------------------------
// bbat_cfg
// coefficient and translation registers behind the write channel
// ---------------------------------------------------------------------------
module bbat_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [bbat_pkg::CFG_IDX_WIDTH-1:0] wr_index,
    input  logic [bbat_pkg::CFG_WIDTH-1:0]   wr_data,
    output bbat_pkg::cfg_t                   cfg
);
    import bbat_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_ROW_FROM_X: cfg_next.row[0]   = wr_data[ROW_WIDTH-1:0];
                REG_ROW_FROM_Y: cfg_next.row[1]   = wr_data[ROW_WIDTH-1:0];
                REG_ROW_FROM_Z: cfg_next.row[2]   = wr_data[ROW_WIDTH-1:0];
                REG_SHIFT_X:    cfg_next.shift[0] = wr_data[COORD_WIDTH-1:0];
                REG_SHIFT_Y:    cfg_next.shift[1] = wr_data[COORD_WIDTH-1:0];
                REG_SHIFT_Z:    cfg_next.shift[2] = wr_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                cfg_reg.row[k]   <= ident_row(k);
                cfg_reg.shift[k] <= '0;
            end
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bbat_term.sv =====
// ---------------------------------------------------------------------------
// bbat_term
// per-axis products rounded down, then min and max of the lo/hi pair
// ---------------------------------------------------------------------------
module bbat_term (
    input  logic                aclk,
    input  bbat_pkg::pipe_ctl_t ctl,
    input  bbat_pkg::cfg_t      cfg,
    input  bbat_pkg::coord_t    lo [bbat_pkg::NUM_AXES],
    input  bbat_pkg::coord_t    hi [bbat_pkg::NUM_AXES],
    output bbat_pkg::term_t     mn [bbat_pkg::NUM_AXES][bbat_pkg::NUM_AXES],
    output bbat_pkg::term_t     mx [bbat_pkg::NUM_AXES][bbat_pkg::NUM_AXES]
);
    import bbat_pkg::*;

    // [k][a]: input axis k feeding output axis a
    term_t lo_term_next [NUM_AXES][NUM_AXES];
    term_t hi_term_next [NUM_AXES][NUM_AXES];
    term_t lo_term_reg  [NUM_AXES][NUM_AXES];
    term_t hi_term_reg  [NUM_AXES][NUM_AXES];
    term_t mn_reg       [NUM_AXES][NUM_AXES];
    term_t mx_reg       [NUM_AXES][NUM_AXES];

    always_comb begin
        prod_t c;
        prod_t pl;
        prod_t ph;
        for (int k = 0; k < NUM_AXES; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                c  = prod_t'(coef_of(cfg.row[k], a));
                pl = prod_t'(lo[k]) * c;
                ph = prod_t'(hi[k]) * c;
                // arithmetic shift rounds toward negative infinity
                lo_term_next[k][a] = term_t'(pl >>> COEF_FRAC);
                hi_term_next[k][a] = term_t'(ph >>> COEF_FRAC);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            lo_term_reg <= lo_term_next;
            hi_term_reg <= hi_term_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_ext) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (lo_term_reg[k][a] < hi_term_reg[k][a]) begin
                        mn_reg[k][a] <= lo_term_reg[k][a];
                        mx_reg[k][a] <= hi_term_reg[k][a];
                    end else begin
                        mn_reg[k][a] <= hi_term_reg[k][a];
                        mx_reg[k][a] <= lo_term_reg[k][a];
                    end
                end
            end
        end
    end

    assign mn = mn_reg;
    assign mx = mx_reg;

endmodule

// ===== rtl/core/bbat_sum.sv =====
// ---------------------------------------------------------------------------
// bbat_sum
// adds the per-axis extremes and the translation, then saturates
// ---------------------------------------------------------------------------
module bbat_sum (
    input  logic                aclk,
    input  bbat_pkg::pipe_ctl_t ctl,
    input  bbat_pkg::cfg_t      cfg,
    input  bbat_pkg::term_t     mn [bbat_pkg::NUM_AXES][bbat_pkg::NUM_AXES],
    input  bbat_pkg::term_t     mx [bbat_pkg::NUM_AXES][bbat_pkg::NUM_AXES],
    output bbat_pkg::coord_t    out_lo [bbat_pkg::NUM_AXES],
    output bbat_pkg::coord_t    out_hi [bbat_pkg::NUM_AXES]
);
    import bbat_pkg::*;

    sum_t   sum_lo_next [NUM_AXES];
    sum_t   sum_hi_next [NUM_AXES];
    sum_t   sum_lo_reg  [NUM_AXES];
    sum_t   sum_hi_reg  [NUM_AXES];
    coord_t out_lo_reg  [NUM_AXES];
    coord_t out_hi_reg  [NUM_AXES];

    function automatic coord_t sat(sum_t v);
        logic [SUM_WIDTH-COORD_WIDTH:0] top;
        top = v[SUM_WIDTH-1:COORD_WIDTH-1];
        if (&top || ~|top) begin
            return v[COORD_WIDTH-1:0];
        end
        return v[SUM_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                              : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            sum_lo_next[a] = sum_t'(cfg.shift[a]);
            sum_hi_next[a] = sum_t'(cfg.shift[a]);
            for (int k = 0; k < NUM_AXES; k++) begin
                sum_lo_next[a] = sum_lo_next[a] + sum_t'(mn[k][a]);
                sum_hi_next[a] = sum_hi_next[a] + sum_t'(mx[k][a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_sum) begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                out_lo_reg[a] <= sat(sum_lo_reg[a]);
                out_hi_reg[a] <= sat(sum_hi_reg[a]);
            end
        end
    end

    assign out_lo = out_lo_reg;
    assign out_hi = out_hi_reg;

endmodule

// ===== rtl/core/bounding_box_affine_transform.sv =====
// path: an accepted box is registered in turn as products, extremes, sums and saturated output, then leaves on m
// throughput: one box per cycle; the four-stage pipeline takes a new box
//   whenever its last stage drains or any stage holds a bubble
// reset: synchronous active-low aresetn clears all stage valid bits and loads
//   the identity matrix and zero translation
// ---------------------------------------------------------------------------
// bounding_box_affine_transform
// encloses an axis-aligned box after a 3x3 matrix and translation
// ---------------------------------------------------------------------------
`include "bounding_box_affine_transform_defines.svh"

module bounding_box_affine_transform (
    input  logic                               aclk,
    input  logic                               aresetn,

    // box input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z from the lowest bit up
    input  logic [bbat_pkg::TDATA_WIDTH-1:0]   s_tdata,

    // enclosing box result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z from the lowest bit up
    output logic [bbat_pkg::TDATA_WIDTH-1:0]   m_tdata,

    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bbat_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [bbat_pkg::CFG_WIDTH-1:0]     cfg_data
);
    import bbat_pkg::*;

    localparam int NUM_STAGES = 4;

    cfg_t      cfg;
    pipe_ctl_t ctl;

    // stage valid bits; the last one is the output register
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] stage_in_valid;

    coord_t in_lo  [NUM_AXES];
    coord_t in_hi  [NUM_AXES];
    term_t  mn     [NUM_AXES][NUM_AXES];
    term_t  mx     [NUM_AXES][NUM_AXES];
    coord_t out_lo [NUM_AXES];
    coord_t out_hi [NUM_AXES];
    logic [BOX_WIDTH-1:0] out_box;

    // registers accept writes at any time
    assign cfg_ready = 1'b1;

    bbat_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // unpack input fields
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            in_lo[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
            in_hi[a] = s_tdata[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    // a stage may load when it is empty or its content moves on this cycle
    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES-2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        stage_in_valid = {valid_reg[NUM_STAGES-2:0], s_tvalid};
        for (int i = 0; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_ready[i] ? stage_in_valid[i] : valid_reg[i];
        end
    end

    assign s_tready = stage_ready[0];

    // data registers load only when a live item arrives
    assign ctl.load_prod = stage_ready[0] && stage_in_valid[0];
    assign ctl.load_ext  = stage_ready[1] && stage_in_valid[1];
    assign ctl.load_sum  = stage_ready[2] && stage_in_valid[2];
    assign ctl.load_out  = stage_ready[3] && stage_in_valid[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stages one and two: products, then lo/hi extremes per term
    bbat_term u_term (
        .aclk (aclk),
        .ctl  (ctl),
        .cfg  (cfg),
        .lo   (in_lo),
        .hi   (in_hi),
        .mn   (mn),
        .mx   (mx)
    );

    // stages three and four: sum with translation, then saturate
    bbat_sum u_sum (
        .aclk   (aclk),
        .ctl    (ctl),
        .cfg    (cfg),
        .mn     (mn),
        .mx     (mx),
        .out_lo (out_lo),
        .out_hi (out_hi)
    );

    // pack result fields
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            out_box[a*COORD_WIDTH +: COORD_WIDTH]            = out_lo[a];
            out_box[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH] = out_hi[a];
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = TDATA_WIDTH'(out_box);

    // any bubble in the pipeline lets a new box in
    `BBAT_ASSERT_NOW(a_bubble_accepts, aclk, aresetn, !(&valid_reg), s_tready)
    // a draining output keeps the whole pipeline flowing
    `BBAT_ASSERT_NOW(a_drain_flows, aclk, aresetn, m_tready, s_tready)
    // an accepted box occupies the first stage on the next cycle
    `BBAT_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
    // a result held on a stall does not vanish
    `BBAT_ASSERT_NEXT(a_stall_keeps, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule
